@@ rtl/ifsf_pkg.sv @@
// ----------------------------------------------------------------------------
// ifsf_pkg
// Shared constants, command word type and stuffing helpers for the framer.
// ----------------------------------------------------------------------------
package ifsf_pkg;

    localparam logic [7:0] FLAG_BYTE = 8'h7E;
    localparam logic [7:0] ESC_BYTE  = 8'h7D;
    localparam logic [7:0] ESC_FLAG  = 8'h5E;
    localparam logic [7:0] ESC_ESC   = 8'h5D;
    localparam logic [7:0] ACK_LOW   = 8'h05;

    localparam logic [7:0] ADDRESS_RESET = 8'h03;

    // APB register map: one 32-bit register, byte address 4*index
    localparam int         PADDR_W         = 3;
    localparam logic       REG_IDX_ADDRESS = 1'b0;

    localparam int         QUEUE_DEPTH_DEF = 2;

    typedef enum logic {
        REQ_PAYLOAD = 1'b0,
        REQ_ACK     = 1'b1
    } t_req;

    // One classified item, handed from the front to the back
    typedef struct packed {
        logic       is_ack;
        logic       ack_ok;
        logic       hdr;      // frame opens with this byte: send header first
        logic [7:0] addr;
        logic [7:0] ctrl;
        logic [7:0] data;
        logic       last;
        logic [7:0] check;    // frame check, valid when last is set
    } t_cmd;

    function automatic logic needs_esc(input logic [7:0] b);
        needs_esc = (b == FLAG_BYTE) || (b == ESC_BYTE);
    endfunction

    function automatic logic [7:0] esc_second(input logic [7:0] b);
        esc_second = (b == FLAG_BYTE) ? ESC_FLAG : ESC_ESC;
    endfunction

endpackage

@@ rtl/info_frame_stuffing_framer_core.sv @@
// ----------------------------------------------------------------------------
// info_frame_stuffing_framer_core
// Stop-and-wait information frame sender with byte stuffing and XOR checks.
// ----------------------------------------------------------------------------
// Each input word is either a payload byte or the fields of a received
// acknowledgment. The first payload byte of a frame is preceded by the header
// (flag 7E, address, control = sequence bit in bit 6, address XOR control),
// payload bytes go out stuffed (7E -> 7D 5E, 7D -> 7D 5D), and the byte marked
// last is followed by the stuffed XOR check of the payload and a closing flag.
// An acknowledgment yields one word with no line byte that reports whether it
// matched; a match toggles the sequence bit. Header bytes are never stuffed.
// Rate: the back end drives one output word per cycle while the output is not
// stalled. An input word makes 1 output word for a plain payload byte or an
// acknowledgment, 2 for an escaped byte, plus 4 when it opens a frame and
// 2 to 3 when it closes one (at most 9). The front classifies one input word
// per cycle while the command queue is not full and keeps the sequence, frame
// and check state, so it can run ahead of the back end by QUEUE_DEPTH words.
// Empty payloads are not supported. The address register is at APB byte
// address 0 and should be written only while the block is idle.
// ----------------------------------------------------------------------------
module info_frame_stuffing_framer_core
    import ifsf_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // APB configuration port
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    // input word channel
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_req_type,
    input  logic [7:0]         i_payload_byte,
    input  logic               i_last_byte,
    input  logic [7:0]         i_ack_address,
    input  logic [7:0]         i_ack_control,
    input  logic [7:0]         i_ack_check,
    // output word channel
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [7:0]         o_out_byte,
    output logic               o_byte_present,
    output logic               o_frame_end,
    output logic               o_ack_accepted,
    output logic               o_run_last
);

    logic [7:0] r_address;
    logic       cfg_wr;

    t_cmd       front_cmd;
    t_cmd       head_cmd;
    logic       q_full;
    logic       q_empty;
    logic       q_pop;
    logic       in_accept;

    // APB: pready is always high; decode the word index only
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_IDX_ADDRESS);
    assign prdata = (paddr[2] == REG_IDX_ADDRESS) ? {24'b0, r_address} : 32'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_address <= ADDRESS_RESET;
        end else if (cfg_wr) begin
            r_address <= pwdata[7:0];
        end
    end

    // hold the input side only while the command queue is full
    assign o_in_stall = q_full;
    assign in_accept  = i_in_valid && !q_full;

    ifsf_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_req_type     (i_req_type),
        .i_payload_byte (i_payload_byte),
        .i_last_byte    (i_last_byte),
        .i_ack_address  (i_ack_address),
        .i_ack_control  (i_ack_control),
        .i_ack_check    (i_ack_check),
        .i_address      (r_address),
        .o_cmd          (front_cmd)
    );

    ifsf_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (in_accept),
        .i_cmd   (front_cmd),
        .i_pop   (q_pop),
        .o_head  (head_cmd),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    ifsf_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head_cmd),
        .i_empty        (q_empty),
        .o_pop          (q_pop),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_byte_present (o_byte_present),
        .o_frame_end    (o_frame_end),
        .o_ack_accepted (o_ack_accepted),
        .o_run_last     (o_run_last)
    );

endmodule

@@ rtl/ifsf_front.sv @@
// ----------------------------------------------------------------------------
// ifsf_front
// Accepts input words, tracks frame and sequence state, classifies each word.
// ----------------------------------------------------------------------------
module ifsf_front
    import ifsf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic       i_req_type,
    input  logic [7:0] i_payload_byte,
    input  logic       i_last_byte,
    input  logic [7:0] i_ack_address,
    input  logic [7:0] i_ack_control,
    input  logic [7:0] i_ack_check,
    input  logic [7:0] i_address,
    output t_cmd       o_cmd
);

    logic       r_seq;
    logic       r_open;
    logic [7:0] r_acc;
    logic       n_seq;
    logic       n_open;
    logic [7:0] n_acc;

    logic [7:0] ack_want;
    logic       ack_ok;
    logic [7:0] acc_sum;
    logic       is_ack;

    assign is_ack   = (t_req'(i_req_type) == REQ_ACK);
    assign ack_want = {~r_seq, 7'b0} | ACK_LOW;
    assign ack_ok   = (i_ack_control == ack_want) &&
                      (i_ack_check == (i_ack_address ^ i_ack_control));
    // restart the check with each new frame
    assign acc_sum  = (r_open ? r_acc : 8'h00) ^ i_payload_byte;

    always_comb begin
        o_cmd.is_ack = is_ack;
        o_cmd.ack_ok = ack_ok;
        o_cmd.hdr    = ~r_open;
        o_cmd.addr   = i_address;
        o_cmd.ctrl   = {1'b0, r_seq, 6'b0};
        o_cmd.data   = i_payload_byte;
        o_cmd.last   = i_last_byte;
        o_cmd.check  = acc_sum;
    end

    always_comb begin
        n_seq  = r_seq;
        n_open = r_open;
        n_acc  = r_acc;
        if (i_accept) begin
            if (is_ack) begin
                n_seq = r_seq ^ ack_ok;
            end else if (i_last_byte) begin
                n_open = 1'b0;
                n_acc  = 8'h00;
            end else begin
                n_open = 1'b1;
                n_acc  = acc_sum;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq  <= 1'b0;
            r_open <= 1'b0;
            r_acc  <= 8'h00;
        end else begin
            r_seq  <= n_seq;
            r_open <= n_open;
            r_acc  <= n_acc;
        end
    end

endmodule

@@ rtl/ifsf_queue.sv @@
// ----------------------------------------------------------------------------
// ifsf_queue
// Small command queue between the front and the back.
// ----------------------------------------------------------------------------
module ifsf_queue
    import ifsf_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_full,
    output logic o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    t_cmd             r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_head  = r_mem[r_rd_ptr];

    function automatic logic [PTR_W-1:0] bump(input logic [PTR_W-1:0] p);
        bump = (p == PTR_W'(DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= bump(r_wr_ptr);
            end
            if (i_pop) begin
                r_rd_ptr <= bump(r_rd_ptr);
            end
            unique case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

@@ rtl/ifsf_back.sv @@
// ----------------------------------------------------------------------------
// ifsf_back
// Expands queued commands into output-register line words, one per unstalled cycle.
// ----------------------------------------------------------------------------
module ifsf_back
    import ifsf_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_cmd       i_head,
    input  logic       i_empty,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_byte_present,
    output logic       o_frame_end,
    output logic       o_ack_accepted,
    output logic       o_run_last
);

    typedef enum logic [10:0] {
        ST_START = 11'b000_0000_0001,
        ST_FLAG  = 11'b000_0000_0010,
        ST_ADDR  = 11'b000_0000_0100,
        ST_CTRL  = 11'b000_0000_1000,
        ST_HCHK  = 11'b000_0001_0000,
        ST_PAY   = 11'b000_0010_0000,
        ST_PAY2  = 11'b000_0100_0000,
        ST_CHK   = 11'b000_1000_0000,
        ST_CHK2  = 11'b001_0000_0000,
        ST_END   = 11'b010_0000_0000,
        ST_ACK   = 11'b100_0000_0000
    } t_state;

    t_state     r_state;
    t_state     n_state;
    t_state     eff;

    logic       r_out_valid;
    logic [7:0] r_out_byte;
    logic       r_byte_present;
    logic       r_frame_end;
    logic       r_ack_accepted;
    logic       r_run_last;

    logic       step;
    logic       done;
    logic [7:0] w_byte;
    logic       w_present;
    logic       w_end;
    logic       w_ack;

    // output register takes a word when empty or being drained
    assign step  = (!r_out_valid || !i_out_stall) && !i_empty;
    assign o_pop = step && done;

    always_comb begin
        if (r_state == ST_START) begin
            if (i_head.is_ack) begin
                eff = ST_ACK;
            end else if (i_head.hdr) begin
                eff = ST_FLAG;
            end else begin
                eff = ST_PAY;
            end
        end else begin
            eff = r_state;
        end
    end

    always_comb begin
        w_byte    = 8'h00;
        w_present = 1'b1;
        w_end     = 1'b0;
        w_ack     = 1'b0;
        done      = 1'b0;
        n_state   = r_state;
        unique case (eff)
            ST_FLAG: begin
                w_byte  = FLAG_BYTE;
                n_state = ST_ADDR;
            end
            ST_ADDR: begin
                w_byte  = i_head.addr;
                n_state = ST_CTRL;
            end
            ST_CTRL: begin
                w_byte  = i_head.ctrl;
                n_state = ST_HCHK;
            end
            ST_HCHK: begin
                w_byte  = i_head.addr ^ i_head.ctrl;
                n_state = ST_PAY;
            end
            ST_PAY: begin
                if (needs_esc(i_head.data)) begin
                    w_byte  = ESC_BYTE;
                    n_state = ST_PAY2;
                end else begin
                    w_byte  = i_head.data;
                    n_state = ST_CHK;
                    done    = ~i_head.last;
                end
            end
            ST_PAY2: begin
                w_byte  = esc_second(i_head.data);
                n_state = ST_CHK;
                done    = ~i_head.last;
            end
            ST_CHK: begin
                if (needs_esc(i_head.check)) begin
                    w_byte  = ESC_BYTE;
                    n_state = ST_CHK2;
                end else begin
                    w_byte  = i_head.check;
                    n_state = ST_END;
                end
            end
            ST_CHK2: begin
                w_byte  = esc_second(i_head.check);
                n_state = ST_END;
            end
            ST_END: begin
                w_byte = FLAG_BYTE;
                w_end  = 1'b1;
                done   = 1'b1;
            end
            ST_ACK: begin
                w_present = 1'b0;
                w_ack     = i_head.ack_ok;
                done      = 1'b1;
            end
            default: begin
                w_present = 1'b0;
                done      = 1'b1;
            end
        endcase
        if (done) begin
            n_state = ST_START;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_START;
            r_out_valid <= 1'b0;
        end else begin
            if (step) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_out_byte     <= w_byte;
            r_byte_present <= w_present;
            r_frame_end    <= w_end;
            r_ack_accepted <= w_ack;
            r_run_last     <= done;
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_out_byte     = r_out_byte;
    assign o_byte_present = r_byte_present;
    assign o_frame_end    = r_frame_end;
    assign o_ack_accepted = r_ack_accepted;
    assign o_run_last     = r_run_last;

endmodule

@@ rtl/ifsf_checker.sv @@
// ----------------------------------------------------------------------------
// ifsf_checker
// Port-level checks on the framer, attached to the top level by bind.
// ----------------------------------------------------------------------------
module ifsf_checker
    import ifsf_pkg::*;
(
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       pready,
    input logic       o_out_valid,
    input logic       i_out_stall,
    input logic [7:0] o_out_byte,
    input logic       o_byte_present,
    input logic       o_frame_end,
    input logic       o_ack_accepted,
    input logic       o_run_last
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=>
            o_out_valid && $stable(o_out_byte) && $stable(o_run_last))
        else $error("stalled output word changed");

    // nothing comes out right after reset
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    // closing flag is a present 7E that ends the run
    a_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_frame_end |->
            o_byte_present && o_run_last && (o_out_byte == FLAG_BYTE))
        else $error("bad closing flag word");

    // acknowledgment result carries no line byte and ends its run
    a_ack_word: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_ack_accepted |->
            !o_byte_present && !o_frame_end && o_run_last && (o_out_byte == 8'h00))
        else $error("bad acknowledgment word");

    // configuration port never waits
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pready)
        else $error("pready low");

endmodule

bind info_frame_stuffing_framer_core ifsf_checker u_ifsf_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .pready         (pready),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_out_byte     (o_out_byte),
    .o_byte_present (o_byte_present),
    .o_frame_end    (o_frame_end),
    .o_ack_accepted (o_ack_accepted),
    .o_run_last     (o_run_last)
);

@@ verif/tb_top.sv @@
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for info_frame_stuffing_framer_core.
// Walk a short table of directed words, then run random phases under several
// address settings. Predict every line word from a private copy of the
// sequence, frame and check state, and compare each delivered word field by
// field with the oldest prediction. Random sender bursts and receiver stall
// patterns move gaps across every phase of frame output.
// ----------------------------------------------------------------------------
module tb_top;
    import ifsf_pkg::*;

    localparam int QUIET_LIMIT = 1000;  // cycles with no word moved on either side
    localparam int HOLD_CYCLES = 80;    // long receiver hold-off
    localparam int TAIL_CYCLES = 16;    // settle after the last expected word
    localparam logic [PADDR_W-1:0] ADDR_REG = PADDR_W'(4 * REG_IDX_ADDRESS);

    // one input word as offered on the input channel
    typedef struct packed {
        t_req       req;
        logic [7:0] data;
        logic       last;
        logic [7:0] ack_addr;
        logic [7:0] ack_ctrl;
        logic [7:0] ack_chk;
    } t_word_in;

    // one word of the framed line stream
    typedef struct packed {
        logic [7:0] line_byte;
        logic       present;
        logic       frame_end;
        logic       ack_ok;
        logic       run_last;
    } t_word_out;

    // directed row: first output word typed in when pin_on is set
    typedef struct {
        t_word_in   w;
        logic       pin_on;
        logic [7:0] pin_b;
        logic       pin_a;
    } t_row;

    logic        i_clk   = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel    = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr = '0;
    logic [31:0] pwdata  = '0;
    logic [31:0] prdata;
    logic        pready;
    logic        i_in_valid  = 1'b0;
    logic        o_in_stall;
    logic        i_out_stall = 1'b0;
    logic        o_out_valid;
    logic [7:0]  o_out_byte;
    logic        o_byte_present;
    logic        o_frame_end;
    logic        o_ack_accepted;
    logic        o_run_last;

    t_word_in    offer   = '0;
    logic        pin_on_q = 1'b0;
    logic [7:0]  pin_b_q  = 8'h00;
    logic        pin_a_q  = 1'b0;

    // predictor state, reset values
    logic [7:0]  addr_reg   = ADDRESS_RESET;
    logic        seq_bit    = 1'b0;
    logic [7:0]  bcc_acc    = 8'h00;
    logic        frame_open = 1'b0;

    t_word_out   run_q[$];          // words of the word being predicted
    t_word_out   line_words_due[$]; // expected line words, oldest first

    int          err_cnt      = 0;
    int          quiet_cycles = 0;
    int          burst_left   = 0;
    logic        gaps_on      = 1'b1;
    logic        gen_seq      = 1'b0; // sequence bit as seen by the generator
    logic        hold_req     = 1'b0;
    logic        hold_done    = 1'b0;

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    info_frame_stuffing_framer_core u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_req_type     (offer.req),
        .i_payload_byte (offer.data),
        .i_last_byte    (offer.last),
        .i_ack_address  (offer.ack_addr),
        .i_ack_control  (offer.ack_ctrl),
        .i_ack_check    (offer.ack_chk),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_out_byte     (o_out_byte),
        .o_byte_present (o_byte_present),
        .o_frame_end    (o_frame_end),
        .o_ack_accepted (o_ack_accepted),
        .o_run_last     (o_run_last)
    );

    // ------------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------------
    function automatic void push_line(input logic [7:0] b, input logic pres,
                                      input logic fend, input logic ok);
        t_word_out w;
        w.line_byte = b;
        w.present   = pres;
        w.frame_end = fend;
        w.ack_ok    = ok;
        w.run_last  = 1'b0;
        run_q.push_back(w);
    endfunction

    // escape a flag or escape byte into two line bytes
    function automatic void push_stuffed(input logic [7:0] b);
        if (b == FLAG_BYTE) begin
            push_line(ESC_BYTE, 1'b1, 1'b0, 1'b0);
            push_line(ESC_FLAG, 1'b1, 1'b0, 1'b0);
        end else if (b == ESC_BYTE) begin
            push_line(ESC_BYTE, 1'b1, 1'b0, 1'b0);
            push_line(ESC_ESC, 1'b1, 1'b0, 1'b0);
        end else begin
            push_line(b, 1'b1, 1'b0, 1'b0);
        end
    endfunction

    // compute the line words caused by one input word into run_q
    function automatic void stuff_and_frame(input t_word_in w);
        logic [7:0] want;
        logic [7:0] ctrl;
        logic       ok;
        run_q.delete();
        if (w.req == REQ_ACK) begin
            want = {~seq_bit, 7'h00} | ACK_LOW;
            ok   = (w.ack_ctrl == want) && (w.ack_chk == (w.ack_addr ^ w.ack_ctrl));
            if (ok)
                seq_bit = ~seq_bit;
            push_line(8'h00, 1'b0, 1'b0, ok);
        end else begin
            if (!frame_open) begin
                // header goes out raw, never stuffed
                ctrl = {1'b0, seq_bit, 6'b0};
                push_line(FLAG_BYTE, 1'b1, 1'b0, 1'b0);
                push_line(addr_reg, 1'b1, 1'b0, 1'b0);
                push_line(ctrl, 1'b1, 1'b0, 1'b0);
                push_line(addr_reg ^ ctrl, 1'b1, 1'b0, 1'b0);
                bcc_acc    = 8'h00;
                frame_open = 1'b1;
            end
            push_stuffed(w.data);
            bcc_acc = bcc_acc ^ w.data;
            if (w.last) begin
                push_stuffed(bcc_acc);
                push_line(FLAG_BYTE, 1'b1, 1'b1, 1'b0);
                bcc_acc    = 8'h00;
                frame_open = 1'b0;
            end
        end
    endfunction

    // ------------------------------------------------------------------------
    // Monitor: predict on input acceptance, check on output acceptance.
    // One process, so a word accepted and answered in the same edge is safe.
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : monitor
        t_word_in  w;
        t_word_out t;
        t_word_out due;
        logic      took_in;
        logic      took_out;
        took_in  = i_rst_n && i_in_valid && !o_in_stall;
        took_out = i_rst_n && (o_out_valid === 1'b1) && !i_out_stall;
        if (took_in) begin
            w.req      = t_req'(offer.req);
            w.data     = offer.data;
            w.last     = offer.last;
            w.ack_addr = offer.ack_addr;
            w.ack_ctrl = offer.ack_ctrl;
            w.ack_chk  = offer.ack_chk;
            stuff_and_frame(w);
            if (pin_on_q) begin
                t = run_q[0];
                t.line_byte = pin_b_q;
                t.ack_ok    = pin_a_q;
                run_q[0] = t;
            end
            t = run_q[run_q.size()-1];
            t.run_last = 1'b1;
            run_q[run_q.size()-1] = t;
            foreach (run_q[i])
                line_words_due.push_back(run_q[i]);
        end
        if (took_out) begin
            if (line_words_due.size() == 0) begin
                err_cnt++;
                if (err_cnt < 50)
                    $display("%0t: unexpected line word %02h/%b/%b/%b/%b", $time,
                             o_out_byte, o_byte_present, o_frame_end,
                             o_ack_accepted, o_run_last);
            end else begin
                due = line_words_due.pop_front();
                if (o_out_byte !== due.line_byte || o_byte_present !== due.present ||
                    o_frame_end !== due.frame_end || o_ack_accepted !== due.ack_ok ||
                    o_run_last !== due.run_last) begin
                    err_cnt++;
                    if (err_cnt < 50)
                        $display({"%0t: line word (byte/present/end/ack/last) ",
                                  "expected %02h/%b/%b/%b/%b, actual %02h/%b/%b/%b/%b"},
                                 $time, due.line_byte, due.present, due.frame_end,
                                 due.ack_ok, due.run_last, o_out_byte, o_byte_present,
                                 o_frame_end, o_ack_accepted, o_run_last);
                end
            end
        end
        if (took_in || took_out)
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    // ------------------------------------------------------------------------
    // Receiver: cycle through stall patterns; honor one long hold-off.
    // ------------------------------------------------------------------------
    initial begin : receiver
        int mode;
        int span;
        int held;
        mode = 0;
        span = 0;
        held = 0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_done) begin
                // hold off while the sender keeps offering, so the block fills up
                if (held == HOLD_CYCLES) begin
                    hold_done = 1'b1;
                    i_out_stall <= 1'b0;
                end else begin
                    held++;
                    i_out_stall <= 1'b1;
                end
            end else begin
                if (span == 0) begin
                    mode = $urandom_range(0, 3);
                    span = $urandom_range(4, 40);
                end
                span--;
                case (mode)
                    0:       i_out_stall <= 1'b0;
                    1:       i_out_stall <= ($urandom_range(0, 99) < 30);
                    2:       i_out_stall <= span[0];
                    default: i_out_stall <= ($urandom_range(0, 99) < 75);
                endcase
            end
        end
    end

    // ------------------------------------------------------------------------
    // Watchdog: end the run when nothing moves for too long.
    // ------------------------------------------------------------------------
    initial begin : watchdog
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge i_clk);
        $display("%0t: no word moved for %0d cycles", $time, QUIET_LIMIT);
        $display("** info_frame_stuffing_framer_core: FAILED **");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Sender and configuration helpers
    // ------------------------------------------------------------------------
    // offer one word and hold it until accepted; open a random gap between bursts
    task automatic offer_word(input t_word_in w, input logic pin_on,
                              input logic [7:0] pin_b, input logic pin_a);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = gaps_on ? $urandom_range(0, 7) : 0;
            if (gap > 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        offer      <= w;
        pin_on_q   <= pin_on;
        pin_b_q    <= pin_b;
        pin_a_q    <= pin_a;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // drop valid and wait for every expected word to come out
    task automatic close_phase();
        i_in_valid <= 1'b0;
        burst_left = 0;
        do @(posedge i_clk); while (line_words_due.size() != 0);
    endtask

    task automatic apb_cycle(input logic wr, input logic [7:0] val,
                             output logic [31:0] rd);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= ADDR_REG;
        pwdata  <= {24'h0, val};
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rd = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic check_address(input logic [7:0] val);
        logic [31:0] rd;
        apb_cycle(1'b0, 8'h00, rd);
        if (rd !== {24'h0, val}) begin
            err_cnt++;
            $display("%0t: address readback expected %08h, actual %08h", $time,
                     {24'h0, val}, rd);
        end
    endtask

    task automatic set_address(input logic [7:0] val);
        logic [31:0] rd;
        apb_cycle(1'b1, val, rd);
        addr_reg = val;
        check_address(val);
    endtask

    // payload byte biased toward the bytes that need escaping
    function automatic logic [7:0] pick_byte();
        case ($urandom_range(0, 9))
            0, 1:    return FLAG_BYTE;
            2, 3:    return ESC_BYTE;
            4:       return $urandom_range(0, 1) ? 8'h00 : 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    // acknowledgment: mostly well-formed, some stale, damaged or pure noise
    function automatic t_word_in make_ack();
        t_word_in   w;
        logic [7:0] want;
        int         r;
        w.req      = REQ_ACK;
        w.data     = 8'($urandom);
        w.last     = 1'($urandom_range(0, 1));
        w.ack_addr = 8'($urandom);
        want = {~gen_seq, 7'h00} | ACK_LOW;
        r = $urandom_range(0, 99);
        if (r < 60) begin
            w.ack_ctrl = want;
            w.ack_chk  = w.ack_addr ^ want;
        end else if (r < 75) begin
            w.ack_ctrl = want ^ 8'h80;
            w.ack_chk  = w.ack_addr ^ w.ack_ctrl;
        end else if (r < 88) begin
            w.ack_ctrl = want;
            w.ack_chk  = w.ack_addr ^ want ^ (8'h01 << $urandom_range(0, 7));
        end else begin
            w.ack_ctrl = 8'($urandom);
            w.ack_chk  = 8'($urandom);
        end
        if (w.ack_ctrl == want && w.ack_chk == (w.ack_addr ^ w.ack_ctrl))
            gen_seq = ~gen_seq;
        return w;
    endfunction

    // mostly whole frames with random content, some acknowledgments between and inside them
    task automatic run_random(input int n_words);
        t_word_in   w;
        logic [7:0] acc;
        int         made;
        int         len;
        made = 0;
        while (made < n_words) begin
            if ($urandom_range(0, 99) < 70) begin
                len = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 24)
                                                   : $urandom_range(1, 6);
                acc = 8'h00;
                for (int i = 0; i < len; i++) begin
                    w.req      = REQ_PAYLOAD;
                    w.last     = (i == len - 1);
                    w.data     = pick_byte();
                    // steer the check byte onto a flag or escape now and then
                    if (w.last && $urandom_range(0, 3) == 0)
                        w.data = acc ^ ($urandom_range(0, 1) ? FLAG_BYTE : ESC_BYTE);
                    w.ack_addr = 8'($urandom);
                    w.ack_ctrl = 8'($urandom);
                    w.ack_chk  = 8'($urandom);
                    acc = acc ^ w.data;
                    offer_word(w, 1'b0, 8'h00, 1'b0);
                    made++;
                    if (!w.last && $urandom_range(0, 9) == 0) begin
                        offer_word(make_ack(), 1'b0, 8'h00, 1'b0);
                        made++;
                    end
                end
            end else begin
                offer_word(make_ack(), 1'b0, 8'h00, 1'b0);
                made++;
            end
        end
    endtask

    function automatic t_row dir_row(input t_req req, input logic [7:0] data,
                                     input logic last, input logic [7:0] a,
                                     input logic [7:0] c, input logic [7:0] k,
                                     input logic pin_on, input logic [7:0] pin_b,
                                     input logic pin_a);
        t_row r;
        r.w.req      = req;
        r.w.data     = data;
        r.w.last     = last;
        r.w.ack_addr = a;
        r.w.ack_ctrl = c;
        r.w.ack_chk  = k;
        r.pin_on     = pin_on;
        r.pin_b      = pin_b;
        r.pin_a      = pin_a;
        return r;
    endfunction

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main
        t_row rows[$];

        // directed words; address 3, sequence 0 after reset
        // frame with raw, flag, escape and all-ones payload bytes
        rows.push_back(dir_row(REQ_PAYLOAD, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b1, 8'h7E, 1'b0));
        rows.push_back(dir_row(REQ_PAYLOAD, 8'h7E, 1'b0, 8'h00, 8'h00, 8'h00, 1'b1, 8'h7D, 1'b0));
        rows.push_back(dir_row(REQ_PAYLOAD, 8'h7D, 1'b0, 8'h00, 8'h00, 8'h00, 1'b1, 8'h7D, 1'b0));
        rows.push_back(dir_row(REQ_PAYLOAD, 8'hFF, 1'b1, 8'h00, 8'h00, 8'h00, 1'b1, 8'hFF, 1'b0));
        // ack with the wrong sequence, then a good one, then a repeat
        rows.push_back(dir_row(REQ_ACK, 8'h00, 1'b0, 8'h03, 8'h05, 8'h06, 1'b1, 8'h00, 1'b0));
        rows.push_back(dir_row(REQ_ACK, 8'h00, 1'b0, 8'hFF, 8'h85, 8'h7A, 1'b1, 8'h00, 1'b1));
        rows.push_back(dir_row(REQ_ACK, 8'h00, 1'b0, 8'hFF, 8'h85, 8'h7A, 1'b1, 8'h00, 1'b0));
        // right control, bad check
        rows.push_back(dir_row(REQ_ACK, 8'h00, 1'b0, 8'h00, 8'h05, 8'h04, 1'b1, 8'h00, 1'b0));
        // one-byte flag frame with sequence 1: nine words, stuffed check
        rows.push_back(dir_row(REQ_PAYLOAD, 8'h7E, 1'b1, 8'h00, 8'h00, 8'h00, 1'b1, 8'h7E, 1'b0));
        // ack inside an open frame; the frame carries on without a new header
        rows.push_back(dir_row(REQ_PAYLOAD, 8'h7D, 1'b0, 8'h00, 8'h00, 8'h00, 1'b1, 8'h7E, 1'b0));
        rows.push_back(dir_row(REQ_ACK, 8'hFF, 1'b1, 8'h00, 8'h05, 8'h05, 1'b1, 8'h00, 1'b1));
        rows.push_back(dir_row(REQ_PAYLOAD, 8'h7C, 1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'h7C, 1'b0));
        // all-ones and all-zeros acks
        rows.push_back(dir_row(REQ_ACK, 8'hFF, 1'b1, 8'hFF, 8'hFF, 8'hFF, 1'b1, 8'h00, 1'b0));
        rows.push_back(dir_row(REQ_ACK, 8'h00, 1'b0, 8'h00, 8'h00, 8'h00, 1'b1, 8'h00, 1'b0));
        // frame whose check works out to a flag, ack in the middle
        rows.push_back(dir_row(REQ_PAYLOAD, 8'h80, 1'b0, 8'h00, 8'h00, 8'h00, 1'b1, 8'h7E, 1'b0));
        rows.push_back(dir_row(REQ_PAYLOAD, 8'h01, 1'b0, 8'h00, 8'h00, 8'h00, 1'b0, 8'h00, 1'b0));
        rows.push_back(dir_row(REQ_ACK, 8'h00, 1'b0, 8'h12, 8'h85, 8'h97, 1'b1, 8'h00, 1'b1));
        rows.push_back(dir_row(REQ_PAYLOAD, 8'hFF, 1'b1, 8'h00, 8'h00, 8'h00, 1'b1, 8'hFF, 1'b0));
        rows.push_back(dir_row(REQ_PAYLOAD, 8'h7E, 1'b1, 8'h00, 8'h00, 8'h00, 1'b1, 8'h7E, 1'b0));

        // hold reset, then read the address register's reset value
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        check_address(ADDRESS_RESET);

        foreach (rows[i])
            offer_word(rows[i].w, rows[i].pin_on, rows[i].pin_b, rows[i].pin_a);
        close_phase();
        gen_seq = seq_bit;

        set_address(8'hFF);
        run_random(90);
        close_phase();

        // long receiver hold-off while the sender keeps offering without gaps
        set_address(8'h00);
        hold_req = 1'b1;
        gaps_on  = 1'b0;
        run_random(60);
        gaps_on  = 1'b1;
        run_random(30);
        close_phase();

        // header bytes equal to flag and escape must still go out raw
        set_address(FLAG_BYTE);
        run_random(90);
        close_phase();

        set_address(ESC_BYTE);
        run_random(90);
        close_phase();

        set_address(8'($urandom));
        run_random(50);
        close_phase();
        run_random(50);
        close_phase();

        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_cnt == 0)
            $display("** info_frame_stuffing_framer_core: PASSED **");
        else
            $display("** info_frame_stuffing_framer_core: FAILED **");
        $finish;
    end

endmodule
